[src/vfc_pkg.sv]
// Shared types and constants for the voxel face culling block.
package vfc_pkg;

  localparam int COORD_W = 4;
  localparam int KIND_W  = 8;
  localparam int DIR_W   = 3;
  localparam int WORLD_W = 16;
  localparam int CHUNK_W = 12;
  localparam int CFG_W   = 1;
  localparam int NUM_DIR = 6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] CFG_CHUNK_X = 1'd0;
  localparam logic [CFG_W-1:0] CFG_CHUNK_Z = 1'd1;

  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd5;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [DIR_W-1:0]   face_dir;
    logic [WORLD_W-1:0] world_x;
    logic [COORD_W-1:0] world_y;
    logic [WORLD_W-1:0] world_z;
    logic               face_valid;
    logic               last;
  } face_rec_t;

endpackage

[src/vfc_store.sv]
// Block type memory with one write and one registered read port, cleared after reset.
module vfc_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vfc_pkg::mem_ctl_t          mem_ctl,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [vfc_pkg::KIND_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [vfc_pkg::KIND_W-1:0] rd_data,
  output logic                       store_rdy
);

  logic [vfc_pkg::KIND_W-1:0] mem [DEPTH];
  logic [vfc_pkg::KIND_W-1:0] rd_data_r;
  logic                       clr_busy_r;
  logic [ADDR_W-1:0]          clr_addr_r;
  logic                       we;
  logic [ADDR_W-1:0]          wa;
  logic [vfc_pkg::KIND_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_busy_r | mem_ctl.wr_en;
    wa = clr_busy_r ? clr_addr_r : wr_addr;
    wd = clr_busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign store_rdy = ~clr_busy_r;

endmodule

[src/vfc_ctrl.sv]
// Item sequencer: cell writes, neighbor reads and face record emission.
module vfc_ctrl #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_DEPTH  = 16,
  parameter int CHUNK_HEIGHT = 16,
  parameter int ADDR_W       = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [vfc_pkg::COORD_W-1:0] in_cell_x,
  input  logic [vfc_pkg::COORD_W-1:0] in_cell_y,
  input  logic [vfc_pkg::COORD_W-1:0] in_cell_z,
  input  logic [vfc_pkg::KIND_W-1:0]  in_block_kind,
  input  logic [vfc_pkg::WORLD_W-1:0] world_x_c,
  input  logic [vfc_pkg::WORLD_W-1:0] world_z_c,
  input  logic                        store_rdy,
  output vfc_pkg::mem_ctl_t           mem_ctl,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [vfc_pkg::KIND_W-1:0]  wr_data,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [vfc_pkg::KIND_W-1:0]  rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vfc_pkg::face_rec_t          out_rec
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'd7;
  localparam int         LAYER     = CHUNK_WIDTH * CHUNK_DEPTH;

  state_t                        state_r, state_nxt;
  logic [2:0]                    step_r;
  logic [ADDR_W-1:0]             cen_addr_r;
  logic [vfc_pkg::NUM_DIR-1:0]   bnd_r;
  logic [vfc_pkg::NUM_DIR-1:0]   vis_r;
  logic                          solid_r;
  logic [vfc_pkg::WORLD_W-1:0]   wx_r;
  logic [vfc_pkg::WORLD_W-1:0]   wz_r;
  logic [vfc_pkg::COORD_W-1:0]   wy_r;
  logic                          out_valid_r;
  vfc_pkg::face_rec_t            out_rec_r;

  logic                          accept;
  logic                          in_chunk;
  logic [ADDR_W-1:0]             cen_addr_c;
  logic [vfc_pkg::NUM_DIR-1:0]   bnd_c;
  logic [vfc_pkg::NUM_DIR-1:0]   emask;
  logic [vfc_pkg::NUM_DIR-1:0]   rest;
  logic [vfc_pkg::DIR_W-1:0]     pick_dir;
  logic                          found;
  logic                          load;
  logic [vfc_pkg::DIR_W-1:0]     cap_dir;

  always_comb begin
    in_chunk = (32'(in_cell_x) < CHUNK_WIDTH) && (32'(in_cell_y) < CHUNK_HEIGHT) &&
               (32'(in_cell_z) < CHUNK_DEPTH);
    cen_addr_c = ADDR_W'(32'(in_cell_x) + 32'(in_cell_z) * CHUNK_WIDTH +
                         32'(in_cell_y) * LAYER);
    bnd_c[vfc_pkg::DIR_WEST]  = 32'(in_cell_z) == CHUNK_DEPTH - 1;
    bnd_c[vfc_pkg::DIR_EAST]  = in_cell_z == '0;
    bnd_c[vfc_pkg::DIR_SOUTH] = 32'(in_cell_x) == CHUNK_WIDTH - 1;
    bnd_c[vfc_pkg::DIR_NORTH] = in_cell_x == '0;
    bnd_c[vfc_pkg::DIR_UP]    = 32'(in_cell_y) == CHUNK_HEIGHT - 1;
    bnd_c[vfc_pkg::DIR_DOWN]  = in_cell_y == '0;
  end

  assign in_ready = (state_r == ST_IDLE) && store_rdy;
  assign accept   = in_valid && in_ready;

  // writes go straight to memory; reads only run in ST_READ, so no overlap
  always_comb begin
    mem_ctl.wr_en = accept && (in_func == vfc_pkg::FUNC_WRITE) && in_chunk;
    mem_ctl.rd_en = (state_r == ST_READ) && (step_r != LAST_STEP);
    wr_addr       = cen_addr_c;
    wr_data       = in_block_kind;
  end

  always_comb begin
    unique case (step_r)
      3'd1:    rd_addr = bnd_r[vfc_pkg::DIR_WEST]  ? cen_addr_r :
                         cen_addr_r + ADDR_W'(CHUNK_WIDTH);
      3'd2:    rd_addr = bnd_r[vfc_pkg::DIR_EAST]  ? cen_addr_r :
                         cen_addr_r - ADDR_W'(CHUNK_WIDTH);
      3'd3:    rd_addr = bnd_r[vfc_pkg::DIR_SOUTH] ? cen_addr_r :
                         cen_addr_r + ADDR_W'(1);
      3'd4:    rd_addr = bnd_r[vfc_pkg::DIR_NORTH] ? cen_addr_r :
                         cen_addr_r - ADDR_W'(1);
      3'd5:    rd_addr = bnd_r[vfc_pkg::DIR_UP]    ? cen_addr_r :
                         cen_addr_r + ADDR_W'(LAYER);
      3'd6:    rd_addr = bnd_r[vfc_pkg::DIR_DOWN]  ? cen_addr_r :
                         cen_addr_r - ADDR_W'(LAYER);
      default: rd_addr = cen_addr_r;
    endcase
  end

  always_comb begin
    emask    = vis_r & {vfc_pkg::NUM_DIR{solid_r}};
    pick_dir = vfc_pkg::DIR_WEST;
    found    = 1'b0;
    for (int i = 0; i < vfc_pkg::NUM_DIR; i++) begin
      if (!found && emask[i]) begin
        pick_dir = vfc_pkg::DIR_W'(i);
        found    = 1'b1;
      end
    end
    rest    = emask & ~(vfc_pkg::NUM_DIR'(1) << pick_dir);
    load    = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
    cap_dir = step_r - 3'd2;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == vfc_pkg::FUNC_QUERY) begin
          state_nxt = in_chunk ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && rest == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // data for the read issued at step s lands at step s+1
  always_ff @(posedge clk) begin
    if (accept) begin
      cen_addr_r <= cen_addr_c;
      bnd_r      <= bnd_c;
      vis_r      <= '0;
      solid_r    <= 1'b0;
      wx_r       <= world_x_c;
      wz_r       <= world_z_c;
      wy_r       <= in_cell_y;
    end else if (state_r == ST_READ) begin
      if (step_r == 3'd1) begin
        solid_r <= rd_data != '0;
      end else if (step_r != 3'd0) begin
        vis_r[cap_dir] <= bnd_r[cap_dir] || (rd_data == '0);
      end
    end else if (load) begin
      vis_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r.face_dir   <= pick_dir;
      out_rec_r.world_x    <= wx_r;
      out_rec_r.world_y    <= wy_r;
      out_rec_r.world_z    <= wz_r;
      out_rec_r.face_valid <= found;
      out_rec_r.last       <= rest == '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> store_rdy)
    else $error("item taken during memory clear");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_ctl.wr_en)
    else $error("memory write while a query is in flight");

  a_read_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && step_r == LAST_STEP) |=> (state_r == ST_EMIT))
    else $error("neighbor reads did not end in emission");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && rest == '0) |=> (state_r == ST_IDLE && out_valid_r && out_rec_r.last))
    else $error("final record did not close the query");

  a_noface_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rec_r.face_valid) |-> out_rec_r.last)
    else $error("no-face record without last");

endmodule

[src/voxel_face_culling_core.sv]
// Voxel face culling core: chunk block store, cell writes and visible face queries.
// A write item goes straight into the memory. A query item reads the center and its six
// neighbors in turn through the single read port of the block memory, then emits one to six
// records, one per visible face or a single no-face record; the next item is not taken until
// the query is done, and the output holding a record back stalls it. A query of a cell
// outside the chunk skips the reads. After reset the memory is cleared to air one cell a
// cycle over all CHUNK_WIDTH*CHUNK_DEPTH*CHUNK_HEIGHT cells (4096 by default); no item is
// accepted meanwhile, configuration writes are. The last record may wait in the output
// register while the next item is accepted.
module voxel_face_culling_core #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_DEPTH  = 16,
  parameter int CHUNK_HEIGHT = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vfc_pkg::CFG_W-1:0]          cfg_index,
  input  logic [vfc_pkg::CHUNK_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [vfc_pkg::COORD_W-1:0]        in_cell_x,
  input  logic [vfc_pkg::COORD_W-1:0]        in_cell_y,
  input  logic [vfc_pkg::COORD_W-1:0]        in_cell_z,
  input  logic [vfc_pkg::KIND_W-1:0]         in_block_kind,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vfc_pkg::DIR_W-1:0]          out_face_dir,
  output logic signed [vfc_pkg::WORLD_W-1:0] out_world_x,
  output logic [vfc_pkg::COORD_W-1:0]        out_world_y,
  output logic signed [vfc_pkg::WORLD_W-1:0] out_world_z,
  output logic                               out_face_valid,
  output logic                               out_last
);

  localparam int CELLS  = CHUNK_WIDTH * CHUNK_DEPTH * CHUNK_HEIGHT;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic signed [vfc_pkg::CHUNK_W-1:0] chunk_x_r;
  logic signed [vfc_pkg::CHUNK_W-1:0] chunk_z_r;
  logic signed [vfc_pkg::WORLD_W-1:0] cx_ext;
  logic signed [vfc_pkg::WORLD_W-1:0] cz_ext;
  logic [vfc_pkg::WORLD_W-1:0]        world_x_c;
  logic [vfc_pkg::WORLD_W-1:0]        world_z_c;
  vfc_pkg::mem_ctl_t                  mem_ctl;
  logic [ADDR_W-1:0]                  wr_addr;
  logic [ADDR_W-1:0]                  rd_addr;
  logic [vfc_pkg::KIND_W-1:0]         wr_data;
  logic [vfc_pkg::KIND_W-1:0]         rd_data;
  logic                               store_rdy;
  vfc_pkg::face_rec_t                 out_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_x_r <= '0;
      chunk_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfc_pkg::CFG_CHUNK_X: chunk_x_r <= cfg_wdata;
        vfc_pkg::CFG_CHUNK_Z: chunk_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // world position wraps to 16 bits
  always_comb begin
    cx_ext    = vfc_pkg::WORLD_W'(chunk_x_r);
    cz_ext    = vfc_pkg::WORLD_W'(chunk_z_r);
    world_x_c = vfc_pkg::WORLD_W'(cx_ext * vfc_pkg::WORLD_W'(CHUNK_WIDTH)) +
                vfc_pkg::WORLD_W'(in_cell_x);
    world_z_c = vfc_pkg::WORLD_W'(cz_ext * vfc_pkg::WORLD_W'(CHUNK_DEPTH)) +
                vfc_pkg::WORLD_W'(in_cell_z);
  end

  vfc_store #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .store_rdy (store_rdy)
  );

  vfc_ctrl #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .CHUNK_DEPTH  (CHUNK_DEPTH),
    .CHUNK_HEIGHT (CHUNK_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_z     (in_cell_z),
    .in_block_kind (in_block_kind),
    .world_x_c     (world_x_c),
    .world_z_c     (world_z_c),
    .store_rdy     (store_rdy),
    .mem_ctl       (mem_ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rec       (out_rec)
  );

  always_comb begin
    out_face_dir   = out_rec.face_dir;
    out_world_x    = out_rec.world_x;
    out_world_y    = out_rec.world_y;
    out_world_z    = out_rec.world_z;
    out_face_valid = out_rec.face_valid;
    out_last       = out_rec.last;
  end

endmodule

[tb/voxel_face_culling_core_tb.sv]
// Testbench for voxel_face_culling_core: directed and random items against a face predictor.
`timescale 1ns / 1ps

module voxel_face_culling_core_tb;
  import vfc_pkg::*;

  localparam int CW = 16;
  localparam int CD = 16;
  localparam int CH = 16;
  localparam int PHASE_ITEMS = 40;
  localparam int SETTLE = 20;

  localparam logic [DIR_W-1:0] DIR_ORDER [NUM_DIR] =
    '{DIR_WEST, DIR_EAST, DIR_SOUTH, DIR_NORTH, DIR_UP, DIR_DOWN};

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [KIND_W-1:0]  kind;
    logic               typed;
    logic [NUM_DIR-1:0] mask;
    logic [WORLD_W-1:0] wx;
    logic [WORLD_W-1:0] wz;
  } step_t;

  // typed rows: mask of visible sides, zero means the no-face record
  localparam step_t PLAN [21] = '{
    '{FUNC_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd15, 4'd15, 4'd15, 8'h00, 1'b1, 6'h00, 16'd15, 16'd15},
    '{FUNC_WRITE, 4'd0,  4'd0,  4'd0,  8'hFF, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 6'h3F, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd15, 4'd15, 4'd15, 8'h01, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd15, 4'd15, 4'd15, 8'h00, 1'b1, 6'h3F, 16'd15, 16'd15},
    '{FUNC_WRITE, 4'd1,  4'd0,  4'd0,  8'h80, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 6'h3B, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd6,  4'd5,  4'd5,  8'h55, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd4,  4'd5,  4'd5,  8'hAA, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd5,  4'd6,  8'h7F, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd5,  4'd4,  8'h02, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd6,  4'd5,  8'h10, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd4,  4'd5,  8'h08, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd5,  4'd5,  8'hC3, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd5,  4'd5,  4'd5,  8'h00, 1'b1, 6'h00, 16'd5,  16'd5},
    '{FUNC_WRITE, 4'd5,  4'd5,  4'd6,  8'h00, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd5,  4'd5,  4'd5,  8'h00, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_WRITE, 4'd5,  4'd5,  4'd5,  8'h00, 1'b0, 6'h00, 16'd0,  16'd0},
    '{FUNC_QUERY, 4'd5,  4'd5,  4'd5,  8'h00, 1'b1, 6'h00, 16'd5,  16'd5},
    '{FUNC_QUERY, 4'd1,  4'd0,  4'd0,  8'h00, 1'b0, 6'h00, 16'd0,  16'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_index = CFG_CHUNK_X;
  logic [CHUNK_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_WRITE;
  logic [COORD_W-1:0] in_cell_x = '0;
  logic [COORD_W-1:0] in_cell_y = '0;
  logic [COORD_W-1:0] in_cell_z = '0;
  logic [KIND_W-1:0] in_block_kind = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIR_W-1:0] out_face_dir;
  logic signed [WORLD_W-1:0] out_world_x;
  logic [COORD_W-1:0] out_world_y;
  logic signed [WORLD_W-1:0] out_world_z;
  logic out_face_valid;
  logic out_last;

  logic [KIND_W-1:0] voxels [CW*CD*CH];
  logic signed [CHUNK_W-1:0] chunk_x_q;
  logic signed [CHUNK_W-1:0] chunk_z_q;
  face_rec_t faces_due [$];
  int mismatches = 0;
  bit calm = 1'b0;

  voxel_face_culling_core #(
    .CHUNK_WIDTH(CW),
    .CHUNK_DEPTH(CD),
    .CHUNK_HEIGHT(CH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y),
    .in_cell_z(in_cell_z),
    .in_block_kind(in_block_kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_face_dir(out_face_dir),
    .out_world_x(out_world_x),
    .out_world_y(out_world_y),
    .out_world_z(out_world_z),
    .out_face_valid(out_face_valid),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit air_at(int x, int y, int z);
    return voxels[x + z*CW + y*CW*CD] == '0;
  endfunction

  task automatic push_faces(logic [NUM_DIR-1:0] mask, logic [WORLD_W-1:0] wx,
                            logic [COORD_W-1:0] y, logic [WORLD_W-1:0] wz);
    face_rec_t r;
    r.world_x = wx;
    r.world_y = y;
    r.world_z = wz;
    if (mask == '0) begin
      r.face_dir = DIR_WEST;
      r.face_valid = 1'b0;
      r.last = 1'b1;
      faces_due.push_back(r);
    end else begin
      for (int d = 0; d < NUM_DIR; d++) begin
        if (mask[d]) begin
          r.face_dir = DIR_ORDER[d];
          r.face_valid = 1'b1;
          r.last = (mask >> (d + 1)) == '0;
          faces_due.push_back(r);
        end
      end
    end
  endtask

  task automatic predict_cell(logic func, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z, logic [KIND_W-1:0] kind);
    int ix, iy, iz;
    bit inb;
    logic [NUM_DIR-1:0] vis;
    ix = int'(x);
    iy = int'(y);
    iz = int'(z);
    inb = ix < CW && iy < CH && iz < CD;
    vis = '0;
    if (func == FUNC_WRITE) begin
      if (inb) voxels[ix + iz*CW + iy*CW*CD] = kind;
    end else begin
      if (inb && !air_at(ix, iy, iz)) begin
        vis[DIR_WEST]  = iz == CD-1 || air_at(ix, iy, iz+1);
        vis[DIR_EAST]  = iz == 0    || air_at(ix, iy, iz-1);
        vis[DIR_SOUTH] = ix == CW-1 || air_at(ix+1, iy, iz);
        vis[DIR_NORTH] = ix == 0    || air_at(ix-1, iy, iz);
        vis[DIR_UP]    = iy == CH-1 || air_at(ix, iy+1, iz);
        vis[DIR_DOWN]  = iy == 0    || air_at(ix, iy-1, iz);
      end
      push_faces(vis, WORLD_W'(ix + int'(chunk_x_q) * CW), y,
                 WORLD_W'(iz + int'(chunk_z_q) * CD));
    end
  endtask

  task automatic drive_item(logic func, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic [KIND_W-1:0] kind);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_z <= z;
    in_block_kind <= kind;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (faces_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_chunk(logic [CHUNK_W-1:0] cx, logic [CHUNK_W-1:0] cz);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHUNK_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= CFG_CHUNK_Z;
    cfg_wdata <= cz;
    @(posedge clk);
    cfg_we <= 1'b0;
    chunk_x_q = cx;
    chunk_z_q = cz;
  endtask

  task automatic flag(string fld, logic [WORLD_W-1:0] want, logic [WORLD_W-1:0] got);
    $display("%0t: %s expected %h got %h", $time, fld, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    face_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (faces_due.size() == 0) begin
        $display("%0t: face record expected none got dir %h", $time, out_face_dir);
        mismatches++;
      end else begin
        want = faces_due.pop_front();
        if (out_face_dir !== want.face_dir)
          flag("face_dir", WORLD_W'(want.face_dir), WORLD_W'(out_face_dir));
        if (out_world_x !== want.world_x) flag("world_x", want.world_x, out_world_x);
        if (out_world_y !== want.world_y)
          flag("world_y", WORLD_W'(want.world_y), WORLD_W'(out_world_y));
        if (out_world_z !== want.world_z) flag("world_z", want.world_z, out_world_z);
        if (out_face_valid !== want.face_valid)
          flag("face_valid", WORLD_W'(want.face_valid), WORLD_W'(out_face_valid));
        if (out_last !== want.last)
          flag("last", WORLD_W'(want.last), WORLD_W'(out_last));
      end
    end
    out_ready <= calm || $urandom_range(99) >= 7;
  end

  initial begin
    #5_000_000;
    $display("voxel_face_culling_core regression: fail");
    $finish;
  end

  initial begin
    logic [COORD_W-1:0] base, x, y, z;
    logic [KIND_W-1:0] kind;
    logic func;
    int pick;
    foreach (voxels[i]) voxels[i] = '0;
    chunk_x_q = '0;
    chunk_z_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      drive_item(PLAN[i].func, PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].kind);
      if (PLAN[i].typed) push_faces(PLAN[i].mask, PLAN[i].wx, PLAN[i].y, PLAN[i].wz);
      else predict_cell(PLAN[i].func, PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].kind);
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: set_chunk(12'h800, 12'h7FF);
        1: set_chunk(12'h7FF, 12'h800);
        default: set_chunk(CHUNK_W'($urandom_range(4095)), CHUNK_W'($urandom_range(4095)));
      endcase
      calm = p == 2;
      base = COORD_W'($urandom_range(12));
      // mostly a small cluster so writes and queries touch the same neighbors
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        func = $urandom_range(99) < 55 ? FUNC_WRITE : FUNC_QUERY;
        pick = $urandom_range(9);
        if (pick < 7) begin
          x = base + COORD_W'($urandom_range(3));
          y = base + COORD_W'($urandom_range(3));
          z = base + COORD_W'($urandom_range(3));
        end else if (pick == 7) begin
          x = $urandom_range(1) ? 4'd15 : 4'd0;
          y = $urandom_range(1) ? 4'd15 : 4'd0;
          z = $urandom_range(1) ? 4'd15 : 4'd0;
        end else begin
          x = COORD_W'($urandom_range(15));
          y = COORD_W'($urandom_range(15));
          z = COORD_W'($urandom_range(15));
        end
        kind = $urandom_range(3) == 0 ? '0 : KIND_W'($urandom_range(255));
        drive_item(func, x, y, z, kind);
        predict_cell(func, x, y, z, kind);
      end
    end

    calm = 1'b0;
    drain();
    if (mismatches == 0 && faces_due.size() == 0) begin
      $display("voxel_face_culling_core regression: pass");
    end else begin
      $display("voxel_face_culling_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/vfc_pkg.sv
src/vfc_store.sv
src/vfc_ctrl.sv
src/voxel_face_culling_core.sv
tb/voxel_face_culling_core_tb.sv
